[rtl/ccw_pkg.sv]
// Package for the coin change way counter: sizes, entry format, sequencer states
// and the way table port bundle. No dependencies.
package ccw_pkg;

    localparam int MAX_COINS  = 16;
    localparam int MAX_AMOUNT = 4096;

    localparam int COIN_W  = 12;
    localparam int TGT_W   = 12;
    localparam int WAYS_W  = 32;
    localparam int ENTRY_W = WAYS_W + 1;
    localparam int ADDR_W  = $clog2(MAX_AMOUNT);
    localparam int CNT_W   = $clog2(MAX_COINS + 1);
    localparam int IDX_W   = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

    localparam logic [ENTRY_W-1:0] ENTRY_ONE = ENTRY_W'(1);
    localparam logic [ENTRY_W-1:0] ENTRY_SAT = {1'b1, {WAYS_W{1'b1}}};

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_CLEAR,
        ENG_COIN,
        ENG_RUN,
        ENG_FETCH,
        ENG_WAIT,
        ENG_DONE
    } eng_state_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [ADDR_W-1:0]  ra_addr;
        logic [ADDR_W-1:0]  rb_addr;
    } ram_req_t;

    typedef struct packed {
        logic              valid;
        logic [WAYS_W-1:0] ways;
        logic              ovf;
    } eng_result_t;

    // bit WAYS_W of an entry marks a saturated count
    function automatic logic [ENTRY_W-1:0] sat_add(input logic [ENTRY_W-1:0] a,
                                                   input logic [ENTRY_W-1:0] b);
        logic [ENTRY_W-1:0] s;
        s = {1'b0, a[WAYS_W-1:0]} + {1'b0, b[WAYS_W-1:0]};
        if (a[WAYS_W] || b[WAYS_W] || s[WAYS_W]) begin
            return ENTRY_SAT;
        end
        return s;
    endfunction

endpackage

[rtl/ccw_way_ram.sv]
// Generic RAM for the way table: one write port, two read ports, registered reads.
// Read during write to the same address returns the old contents.
module ccw_way_ram #(
    parameter int DATA_W = 33,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] ra_addr,
    input  logic [ADDR_W-1:0] rb_addr,
    output logic [DATA_W-1:0] ra_data,
    output logic [DATA_W-1:0] rb_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

[rtl/ccw_coin_store.sv]
// Coin list: denomination registers, fill count and drop flag.
// Depends on ccw_pkg.
module ccw_coin_store (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  logic [ccw_pkg::COIN_W-1:0] load_den,
    input  logic                       clear,
    input  logic [ccw_pkg::IDX_W-1:0]  rd_idx,
    output logic [ccw_pkg::COIN_W-1:0] rd_den,
    output logic [ccw_pkg::CNT_W-1:0]  count,
    output logic                       dropped
);
    import ccw_pkg::*;

    logic [COIN_W-1:0] coin_reg [MAX_COINS];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              drop_reg, drop_next;
    logic              store_en;

    always_comb begin
        count_next = count_reg;
        drop_next  = drop_reg;
        store_en   = 1'b0;
        if (clear) begin
            count_next = '0;
            drop_next  = 1'b0;
        end else if (load && (load_den != '0)) begin
            if (count_reg < CNT_W'(MAX_COINS)) begin
                store_en   = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end else begin
                drop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            coin_reg[count_reg[IDX_W-1:0]] <= load_den;
        end
    end

    assign rd_den  = coin_reg[rd_idx];
    assign count   = count_reg;
    assign dropped = drop_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_COINS))
        else $error("coin count beyond capacity");

    a_full_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !clear && (load_den != '0) && (count_reg == CNT_W'(MAX_COINS)))
        |=> drop_reg)
        else $error("load into full list did not set drop flag");

endmodule

[rtl/ccw_engine.sv]
// Sequencer with one saturating adder: clears the way table up to the target, then for
// each coin updates ways[v] += ways[v-d] one entry per cycle. Depends on ccw_pkg.
module ccw_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ccw_pkg::TGT_W-1:0]  start_tgt,
    input  logic                       res_ack,
    output logic                       idle,
    output ccw_pkg::eng_result_t       result,
    output logic [ccw_pkg::IDX_W-1:0]  coin_idx,
    input  logic [ccw_pkg::COIN_W-1:0] coin_den,
    input  logic [ccw_pkg::CNT_W-1:0]  coin_count,
    output ccw_pkg::ram_req_t          ram_req,
    input  logic [ccw_pkg::ENTRY_W-1:0] ra_data,
    input  logic [ccw_pkg::ENTRY_W-1:0] rb_data
);
    import ccw_pkg::*;

    eng_state_t         state_reg, state_next;
    logic [TGT_W-1:0]   tgt_reg, tgt_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [COIN_W-1:0]  d_reg, d_next;
    logic [ADDR_W-1:0]  v_reg, v_next;
    logic               iss_reg, iss_next;
    logic               p_valid_reg, p_valid_next;
    logic [ADDR_W-1:0]  p_addr_reg, p_addr_next;
    logic [ADDR_W-1:0]  p_baddr_reg, p_baddr_next;
    logic               w_valid_reg, w_valid_next;
    logic [ADDR_W-1:0]  w_addr_reg, w_addr_next;
    logic [ENTRY_W-1:0] w_data_reg, w_data_next;
    logic [WAYS_W-1:0]  ways_reg, ways_next;
    logic               ovf_reg, ovf_next;
    logic [ADDR_W-1:0]  tgt_addr;
    logic               fwd;
    logic [ENTRY_W-1:0] b_oper;
    logic [ENTRY_W-1:0] sum;

    assign tgt_addr = ADDR_W'(tgt_reg);
    // d == 1: the lower operand is the entry written in the previous cycle
    assign fwd      = w_valid_reg && (w_addr_reg == p_baddr_reg);
    assign b_oper   = fwd ? w_data_reg : rb_data;
    assign sum      = sat_add(ra_data, b_oper);

    always_comb begin
        state_next   = state_reg;
        tgt_next     = tgt_reg;
        clr_next     = clr_reg;
        idx_next     = idx_reg;
        d_next       = d_reg;
        v_next       = v_reg;
        iss_next     = iss_reg;
        p_valid_next = 1'b0;
        p_addr_next  = p_addr_reg;
        p_baddr_next = p_baddr_reg;
        w_valid_next = 1'b0;
        w_addr_next  = w_addr_reg;
        w_data_next  = w_data_reg;
        ways_next    = ways_reg;
        ovf_next     = ovf_reg;
        ram_req.we      = 1'b0;
        ram_req.waddr   = clr_reg;
        ram_req.wdata   = (clr_reg == '0) ? ENTRY_ONE : '0;
        ram_req.ra_addr = v_reg;
        ram_req.rb_addr = v_reg - ADDR_W'(d_reg);

        case (state_reg)
            ENG_IDLE: begin
                if (start) begin
                    tgt_next  = start_tgt;
                    clr_next  = '0;
                    idx_next  = '0;
                    ways_next = '0;
                    ovf_next  = 1'b0;
                    if (32'(start_tgt) >= 32'(MAX_AMOUNT)) begin
                        state_next = ENG_DONE;
                    end else begin
                        state_next = ENG_CLEAR;
                    end
                end
            end
            ENG_CLEAR: begin
                ram_req.we = 1'b1;
                clr_next   = clr_reg + ADDR_W'(1);
                if (clr_reg == tgt_addr) begin
                    state_next = ENG_COIN;
                end
            end
            ENG_COIN: begin
                if (idx_reg == coin_count) begin
                    state_next = ENG_FETCH;
                end else if (coin_den > tgt_reg) begin
                    idx_next = idx_reg + CNT_W'(1);
                end else begin
                    d_next     = coin_den;
                    v_next     = ADDR_W'(coin_den);
                    iss_next   = 1'b1;
                    state_next = ENG_RUN;
                end
            end
            ENG_RUN: begin
                if (iss_reg) begin
                    p_valid_next = 1'b1;
                    p_addr_next  = v_reg;
                    p_baddr_next = v_reg - ADDR_W'(d_reg);
                    if (v_reg == tgt_addr) begin
                        iss_next = 1'b0;
                    end else begin
                        v_next = v_reg + ADDR_W'(1);
                    end
                end
                if (p_valid_reg) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = p_addr_reg;
                    ram_req.wdata = sum;
                    w_valid_next  = 1'b1;
                    w_addr_next   = p_addr_reg;
                    w_data_next   = sum;
                end
                if (!iss_reg && !p_valid_reg) begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ENG_COIN;
                end
            end
            ENG_FETCH: begin
                ram_req.ra_addr = tgt_addr;
                state_next      = ENG_WAIT;
            end
            ENG_WAIT: begin
                ways_next  = ra_data[WAYS_W-1:0];
                ovf_next   = ra_data[WAYS_W];
                state_next = ENG_DONE;
            end
            ENG_DONE: begin
                if (res_ack) begin
                    state_next = ENG_IDLE;
                end
            end
            default: begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ENG_IDLE;
            iss_reg     <= 1'b0;
            p_valid_reg <= 1'b0;
            w_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iss_reg     <= iss_next;
            p_valid_reg <= p_valid_next;
            w_valid_reg <= w_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tgt_reg     <= tgt_next;
        clr_reg     <= clr_next;
        idx_reg     <= idx_next;
        d_reg       <= d_next;
        v_reg       <= v_next;
        p_addr_reg  <= p_addr_next;
        p_baddr_reg <= p_baddr_next;
        w_addr_reg  <= w_addr_next;
        w_data_reg  <= w_data_next;
        ways_reg    <= ways_next;
        ovf_reg     <= ovf_next;
    end

    assign idle         = (state_reg == ENG_IDLE);
    assign coin_idx     = idx_reg[IDX_W-1:0];
    assign result.valid = (state_reg == ENG_DONE);
    assign result.ways  = ways_reg;
    assign result.ovf   = ovf_reg;

    a_fwd_unit_coin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ENG_RUN && p_valid_reg && fwd) |-> (d_reg == COIN_W'(1)))
        else $error("forwarding used for a coin other than one");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.we |-> (ram_req.waddr <= tgt_addr))
        else $error("way table write beyond target");

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ENG_RUN && !iss_reg && !p_valid_reg) |=> (state_reg == ENG_COIN))
        else $error("update pass did not return to coin fetch");

endmodule

[rtl/coin_change_way_counter.sv]
// Coin change way counter, top level: coin list, way table RAM, update sequencer
// and result register. Depends on ccw_pkg, ccw_coin_store, ccw_way_ram, ccw_engine.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | s_valid / s_ready    | s_op, s_denomination, s_target
//  result   | m_valid / m_ready    | m_ways, m_overflowed, m_coins_dropped
//
// A compute transaction for target T clears way table entries 0 to T, then makes one
// update pass over d..T for each loaded coin d <= T and reads entry T; its pace is
// set by the single write port of the way table (one entry update per cycle).
// s_ready is low while a compute runs; a finished compute also holds there while
// the previous result is still unaccepted. A waiting result does not block loads.
// Synchronous active-low reset clears the coin list, sequencer and m_valid.
module coin_change_way_counter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [ccw_pkg::COIN_W-1:0]  s_denomination,
    input  logic [ccw_pkg::TGT_W-1:0]   s_target,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ccw_pkg::WAYS_W-1:0]  m_ways,
    output logic                        m_overflowed,
    output logic                        m_coins_dropped
);
    import ccw_pkg::*;

    logic               eng_idle;
    eng_result_t        eng_res;
    ram_req_t           ram_req;
    logic [IDX_W-1:0]   coin_idx;
    logic [COIN_W-1:0]  coin_den;
    logic [CNT_W-1:0]   coin_count;
    logic               coin_dropped;
    logic [ENTRY_W-1:0] ra_data;
    logic [ENTRY_W-1:0] rb_data;
    logic               s_fire;
    logic               res_ack;
    logic               m_valid_reg, m_valid_next;
    logic [WAYS_W-1:0]  m_ways_reg;
    logic               m_ovf_reg;
    logic               m_drop_reg;

    assign s_ready = eng_idle;
    assign s_fire  = s_valid && s_ready;
    assign res_ack = eng_res.valid && (!m_valid_reg || m_ready);

    ccw_coin_store u_coins (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_fire && !s_op),
        .load_den (s_denomination),
        .clear    (res_ack),
        .rd_idx   (coin_idx),
        .rd_den   (coin_den),
        .count    (coin_count),
        .dropped  (coin_dropped)
    );

    ccw_way_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (MAX_AMOUNT),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_req.we),
        .waddr   (ram_req.waddr),
        .wdata   (ram_req.wdata),
        .ra_addr (ram_req.ra_addr),
        .rb_addr (ram_req.rb_addr),
        .ra_data (ra_data),
        .rb_data (rb_data)
    );

    ccw_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_fire && s_op),
        .start_tgt  (s_target),
        .res_ack    (res_ack),
        .idle       (eng_idle),
        .result     (eng_res),
        .coin_idx   (coin_idx),
        .coin_den   (coin_den),
        .coin_count (coin_count),
        .ram_req    (ram_req),
        .ra_data    (ra_data),
        .rb_data    (rb_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ack) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ack) begin
            m_ways_reg <= eng_res.ways;
            m_ovf_reg  <= eng_res.ovf;
            m_drop_reg <= coin_dropped;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ways          = m_ways_reg;
    assign m_overflowed    = m_ovf_reg;
    assign m_coins_dropped = m_drop_reg;

    a_ack_clears_list: assert property (@(posedge aclk) disable iff (!aresetn)
        res_ack |=> (coin_count == '0) && !coin_dropped)
        else $error("coin list not cleared after compute");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !res_ack)
        else $error("pending result overwritten");

endmodule

[sim/coin_change_way_counter_tb.sv]
// Self-checking testbench for coin_change_way_counter: random load/compute traffic with
// idle gaps and stalls, checked against a built-in way-count predictor.
// Depends on ccw_pkg and the coin_change_way_counter RTL.
`timescale 1ns / 100ps

module coin_change_way_counter_tb;
    import ccw_pkg::*;

    localparam int CYCLE_LIMIT = 2_500_000;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMPUTE = 1'b1
    } ccw_op_t;

    typedef struct {
        ccw_op_t           op;
        logic [COIN_W-1:0] den;
        logic [TGT_W-1:0]  tgt;
        bit                drain;
    } coin_req_t;

    typedef struct {
        logic [WAYS_W-1:0] ways;
        logic              ovf;
        logic              dropped;
    } ways_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_op;
    logic [COIN_W-1:0]  s_denomination;
    logic [TGT_W-1:0]   s_target;
    logic               m_valid;
    logic               m_ready;
    logic [WAYS_W-1:0]  m_ways;
    logic               m_overflowed;
    logic               m_coins_dropped;

    coin_req_t          pending_reqs[$];
    ways_result_t       expected_counts[$];

    logic [COIN_W-1:0]  coin_kinds[MAX_COINS];
    int                 kind_count;
    logic               kinds_overrun;
    logic [ENTRY_W-1:0] combo_table[MAX_AMOUNT];

    bit                 in_taken;
    int                 gap_left;
    int                 stall_left;
    int                 quiet_left;
    int                 cycle_count;
    int                 mismatches;
    int                 n_loads;
    int                 n_computes;
    int                 n_saturated;
    int                 n_dropped;
    int                 n_checked;
    coin_req_t          next_req;
    coin_req_t          seen_req;
    ways_result_t       want;

    coin_change_way_counter i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_denomination  (s_denomination),
        .s_target        (s_target),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ways          (m_ways),
        .m_overflowed    (m_overflowed),
        .m_coins_dropped (m_coins_dropped)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 50);
    endfunction

    task automatic add_load(input logic [COIN_W-1:0] den);
        coin_req_t req;
        req.op    = OP_LOAD;
        req.den   = den;
        req.tgt   = TGT_W'($urandom_range(0, 4095));
        req.drain = 1'b0;
        pending_reqs.push_back(req);
    endtask

    task automatic add_compute(input logic [TGT_W-1:0] tgt, input bit drain);
        coin_req_t req;
        req.op    = OP_COMPUTE;
        req.den   = COIN_W'($urandom_range(0, 4095));
        req.tgt   = tgt;
        req.drain = drain;
        pending_reqs.push_back(req);
    endtask

    // coin list update on load, bottom-up way count on compute
    task automatic count_ways(input coin_req_t req);
        ways_result_t       res;
        logic [ENTRY_W-1:0] sum;
        logic [ENTRY_W-1:0] hi;
        logic [ENTRY_W-1:0] lo;
        int                 d;
        if (req.op == OP_LOAD) begin
            n_loads++;
            if (req.den != '0) begin
                if (kind_count < MAX_COINS) begin
                    coin_kinds[IDX_W'(kind_count)] = req.den;
                    kind_count++;
                end else begin
                    kinds_overrun = 1'b1;
                end
            end
        end else begin
            n_computes++;
            res.ways    = '0;
            res.ovf     = 1'b0;
            res.dropped = kinds_overrun;
            if (int'(req.tgt) < MAX_AMOUNT) begin
                combo_table[0] = ENTRY_ONE;
                for (int v = 1; v <= int'(req.tgt); v++) begin
                    combo_table[ADDR_W'(v)] = '0;
                end
                for (int c = 0; c < kind_count; c++) begin
                    d = int'(coin_kinds[IDX_W'(c)]);
                    for (int v = d; v <= int'(req.tgt); v++) begin
                        hi  = combo_table[ADDR_W'(v)];
                        lo  = combo_table[ADDR_W'(v - d)];
                        sum = {1'b0, hi[WAYS_W-1:0]} + {1'b0, lo[WAYS_W-1:0]};
                        if (hi[WAYS_W] || lo[WAYS_W] || sum[WAYS_W]) begin
                            combo_table[ADDR_W'(v)] = ENTRY_SAT;
                        end else begin
                            combo_table[ADDR_W'(v)] = sum;
                        end
                    end
                end
                res.ways = combo_table[req.tgt][WAYS_W-1:0];
                res.ovf  = combo_table[req.tgt][WAYS_W];
            end
            n_saturated += int'(res.ovf);
            n_dropped   += int'(res.dropped);
            kind_count    = 0;
            kinds_overrun = 1'b0;
            expected_counts.push_back(res);
        end
    endtask

    // driver: source and sink handshakes change on the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (quiet_left > 0) begin
                quiet_left--;
            end else if ($urandom_range(0, 299) == 0) begin
                quiet_left = $urandom_range(40, 150);
            end

            if (!s_valid || in_taken) begin
                if (gap_left > 0 && quiet_left == 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0
                             && !(pending_reqs[0].drain && expected_counts.size() > 0)) begin
                    next_req = pending_reqs.pop_front();
                    s_valid        <= 1'b1;
                    s_op           <= next_req.op;
                    s_denomination <= next_req.den;
                    s_target       <= next_req.tgt;
                    gap_left = idle_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end

            if (quiet_left > 0) begin
                stall_left = 0;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = idle_len();
                end
            end
        end
    end

    // monitor: both channels sampled on the rising edge
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end

        if (aresetn && m_valid && m_ready) begin
            if (expected_counts.size() == 0) begin
                $error("unexpected transaction: m_ways %0h", m_ways);
                mismatches++;
            end else begin
                want = expected_counts.pop_front();
                n_checked++;
                if (m_ways !== want.ways) begin
                    $error("m_ways: expected %0h, actual %0h", want.ways, m_ways);
                    mismatches++;
                end
                if (m_overflowed !== want.ovf) begin
                    $error("m_overflowed: expected %0b, actual %0b", want.ovf, m_overflowed);
                    mismatches++;
                end
                if (m_coins_dropped !== want.dropped) begin
                    $error("m_coins_dropped: expected %0b, actual %0b",
                           want.dropped, m_coins_dropped);
                    mismatches++;
                end
            end
        end

        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) begin
            seen_req.op    = ccw_op_t'(s_op);
            seen_req.den   = s_denomination;
            seen_req.tgt   = s_target;
            seen_req.drain = 1'b0;
            count_ways(seen_req);
        end
    end

    initial begin
        int nload;
        int big_left;
        int r;
        logic [TGT_W-1:0]  tgt;
        logic [COIN_W-1:0] den;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_op           = 1'b0;
        s_denomination = '0;
        s_target       = '0;
        m_ready        = 1'b0;
        in_taken       = 1'b0;
        gap_left       = 0;
        stall_left     = 0;
        quiet_left     = 0;
        cycle_count    = 0;
        mismatches     = 0;
        n_loads        = 0;
        n_computes     = 0;
        n_saturated    = 0;
        n_dropped      = 0;
        n_checked      = 0;
        kind_count     = 0;
        kinds_overrun  = 1'b0;

        // directed: empty list, extreme target, zero coin, full list and saturation
        add_compute(12'd0, 1'b0);
        add_compute(12'd4095, 1'b0);
        add_load(12'd0);
        add_load(12'd4095);
        add_load(12'd1);
        add_compute(12'd4095, 1'b0);
        for (int i = 0; i < MAX_COINS; i++) begin
            add_load(12'd1);
        end
        add_load(12'd4095);
        add_compute(12'd200, 1'b0);
        add_compute(12'd5, 1'b1);

        big_left = 3;
        while (pending_reqs.size() < 100) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    add_load(COIN_W'($urandom_range(0, 4095)));
                end else begin
                    add_compute(TGT_W'($urandom_range(0, 63)), 1'b0);
                end
            end else begin
                nload = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20)
                                                    : $urandom_range(0, 6);
                for (int i = 0; i < nload; i++) begin
                    r = $urandom_range(0, 9);
                    if (r < 7) begin
                        den = COIN_W'($urandom_range(1, 12));
                    end else if (r < 9) begin
                        den = COIN_W'($urandom_range(13, 4095));
                    end else begin
                        den = '0;
                    end
                    add_load(den);
                end
                if (big_left > 0 && $urandom_range(0, 11) == 0) begin
                    big_left--;
                    tgt = TGT_W'($urandom_range(3000, 4095));
                end else if ($urandom_range(0, 3) != 0) begin
                    tgt = TGT_W'($urandom_range(0, 60));
                end else begin
                    tgt = TGT_W'($urandom_range(0, 400));
                end
                add_compute(tgt, $urandom_range(0, 7) == 0);
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        do begin
            @(negedge aclk);
        end while (pending_reqs.size() != 0 || s_valid || expected_counts.size() != 0);
        repeat (40) @(posedge aclk);

        $display("Ran %0d loads and %0d computes; %0d counts checked",
                 n_loads, n_computes, n_checked);
        $display("Saturated counts: %0d, computes with dropped coins: %0d",
                 n_saturated, n_dropped);
        if (mismatches == 0 && expected_counts.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
